// ----- hw/rtl/flp_pkg.sv -----
// Shared types, widths and position tables of the four-lepton pairing block.
// No dependencies; every other file of the block but flp_ram imports this package.
`default_nettype none

package flp_pkg;

    // Field widths
    localparam int INDEX_BITS   = 10;
    localparam int ANGLE_BITS   = 12;
    localparam int ETA_BITS     = ANGLE_BITS + 1;
    localparam int PARTNER_BITS = INDEX_BITS + 1;

    // Event bookkeeping
    localparam int MAX_LEPTONS     = 4;
    localparam int LEPTON_POS_BITS = 2;
    localparam int COUNT_BITS      = 3;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(MAX_LEPTONS);
    localparam logic [COUNT_BITS-1:0] COUNT_SAT  = COUNT_BITS'(MAX_LEPTONS + 1);

    // Number of candidate pairs scanned, and of splits into two pairs
    localparam int NUM_PAIRS  = 6;
    localparam int PAIR_BITS  = 3;
    localparam int NUM_SPLITS = 3;

    // Distance arithmetic
    localparam int SQ_BITS   = 2 * ETA_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;

    // Stored angles: eta in the low bits, phi above
    localparam int ENTRY_BITS = ETA_BITS + ANGLE_BITS;

    // Input tdata layout
    localparam int IN_ETA_LSB     = 0;
    localparam int IN_PHI_LSB     = IN_ETA_LSB + ETA_BITS;
    localparam int IN_OWN_LSB     = IN_PHI_LSB + ANGLE_BITS;
    localparam int IN_PARTNER_LSB = IN_OWN_LSB + INDEX_BITS;
    localparam int IN_FIELD_BITS  = IN_PARTNER_LSB + PARTNER_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Output tdata and tuser layout
    localparam int OUT_FIELD_BITS = 4 * LEPTON_POS_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 2;
    localparam int USER_VALID     = 0;
    localparam int USER_MATCH     = 1;

    // A pairing: found flag and the four positions, lower position first in each pair
    typedef struct packed {
        logic                       found;
        logic [LEPTON_POS_BITS-1:0] p1_first;
        logic [LEPTON_POS_BITS-1:0] p1_second;
        logic [LEPTON_POS_BITS-1:0] p2_first;
        logic [LEPTON_POS_BITS-1:0] p2_second;
    } pairing_t;

    // Position table. Rows 0 to 5 list the candidate pairs in scan order (i, then j)
    // with the two remaining positions after them; rows 0 to 2 are also the three splits.
    function automatic logic [LEPTON_POS_BITS-1:0] pair_pos(
        input logic [PAIR_BITS-1:0]       row,
        input logic [LEPTON_POS_BITS-1:0] slot
    );
        logic [4*LEPTON_POS_BITS-1:0] line;
        unique case (row)
            3'd0:    line = {2'd3, 2'd2, 2'd1, 2'd0};
            3'd1:    line = {2'd3, 2'd1, 2'd2, 2'd0};
            3'd2:    line = {2'd2, 2'd1, 2'd3, 2'd0};
            3'd3:    line = {2'd3, 2'd0, 2'd2, 2'd1};
            3'd4:    line = {2'd2, 2'd0, 2'd3, 2'd1};
            3'd5:    line = {2'd1, 2'd0, 2'd3, 2'd2};
            default: line = {2'd3, 2'd2, 2'd1, 2'd0};
        endcase
        return line[slot*LEPTON_POS_BITS +: LEPTON_POS_BITS];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/four_lepton_pairing.sv -----
// Top level of the four-lepton pairing block: input handling, sequencer, output register.
// Depends on flp_pkg, flp_ram, flp_sq_unit and flp_match.
`default_nettype none

// Leptons stream in one request per cycle while the block is idle; the first four of an event
// are kept at positions 0 to 3 and the request with tlast closes the event and yields one result.
// With four leptons in electron mode and a reciprocal partner pair, or with a lepton
// count other than four, the result goes from the check state straight to the done state.
// Otherwise the six pair distances go one by one through a single shared squarer
// (read, difference, two squares, sum, compare), so after the last request the block
// takes no new request until all six distances have been compared. The result
// sits in an output register, so loading of the next event may start while it waits.
module four_lepton_pairing
    import flp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Lepton requests
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // tdata from bit 0: lepton_eta, lepton_phi, own_index, partner_index, zero fill
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // tuser: is_electron
    input  wire logic                     s_tuser,
    input  wire logic                     s_tlast,
    // Pairing results
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // tdata from bit 0: pair1_first, pair1_second, pair2_first, pair2_second
    output logic      [OUT_DATA_BITS-1:0] m_tdata,
    // tuser from bit 0: valid_res, used_partner_match
    output logic      [OUT_USER_BITS-1:0] m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DIFF,
        ST_SQ_PHI,
        ST_SUM,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t                                  state_reg, state_next;
    logic [COUNT_BITS-1:0]                   count_reg, count_next;
    logic                                    electron_reg, electron_next;
    logic [MAX_LEPTONS-1:0][INDEX_BITS-1:0]   own_reg, own_next;
    logic [MAX_LEPTONS-1:0][PARTNER_BITS-1:0] partner_reg, partner_next;
    logic [PAIR_BITS-1:0]                    pair_idx_reg, pair_idx_next;
    logic [ANGLE_BITS-1:0]                   dphi_abs_reg, dphi_abs_next;
    logic [SQ_BITS-1:0]                      eta_sq_reg, eta_sq_next;
    logic [DIST_BITS-1:0]                    dist_reg, dist_next;
    logic [DIST_BITS-1:0]                    d1_reg, d1_next;
    logic [DIST_BITS-1:0]                    best_key_reg, best_key_next;
    logic [LEPTON_POS_BITS-1:0]              best_split_reg, best_split_next;
    logic [OUT_DATA_BITS-1:0]                res_data_reg, res_data_next;
    logic [OUT_USER_BITS-1:0]                res_user_reg, res_user_next;
    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0]                out_data_reg, out_data_next;
    logic [OUT_USER_BITS-1:0]                out_user_reg, out_user_next;

    logic                       accept;
    logic                       store_we;
    logic [ENTRY_BITS-1:0]      rd_a, rd_b;
    logic [LEPTON_POS_BITS-1:0] raddr_a, raddr_b;
    logic [ETA_BITS-1:0]        sq_op;
    logic [SQ_BITS-1:0]         sq_out;
    pairing_t                   match;

    logic [ETA_BITS:0]          de;
    logic [ETA_BITS:0]          de_abs;
    logic [ANGLE_BITS-1:0]      dp;
    logic [ANGLE_BITS-1:0]      dp_abs;
    logic [DIST_BITS-1:0]       key;
    logic                       take_split;
    logic [LEPTON_POS_BITS-1:0] cur_split;
    logic [LEPTON_POS_BITS-1:0] chosen_split;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign store_we = accept && (count_reg < COUNT_FULL);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Angle store: written in arrival order, read at the two ends of the current pair.
    assign raddr_a = pair_pos(PAIR_BITS'(pair_idx_reg[PAIR_BITS-1:1]), {pair_idx_reg[0], 1'b0});
    assign raddr_b = pair_pos(PAIR_BITS'(pair_idx_reg[PAIR_BITS-1:1]), {pair_idx_reg[0], 1'b1});

    flp_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_LEPTONS)
    ) u_angle_ram (
        .aclk    (aclk),
        .we      (store_we),
        .waddr   (count_reg[LEPTON_POS_BITS-1:0]),
        .wdata   ({s_tdata[IN_PHI_LSB +: ANGLE_BITS], s_tdata[IN_ETA_LSB +: ETA_BITS]}),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    flp_sq_unit u_sq (
        .aclk   (aclk),
        .op     (sq_op),
        .sq_reg (sq_out)
    );

    flp_match u_match (
        .own_idx     (own_reg),
        .partner_idx (partner_reg),
        .match       (match)
    );

    // Absolute eta difference and wrapped absolute phi difference of the pair read.
    always_comb begin
        de     = {rd_a[ETA_BITS-1], rd_a[ETA_BITS-1:0]} - {rd_b[ETA_BITS-1], rd_b[ETA_BITS-1:0]};
        de_abs = de[ETA_BITS] ? (~de + 1'b1) : de;
        dp     = rd_a[ETA_BITS +: ANGLE_BITS] - rd_b[ETA_BITS +: ANGLE_BITS];
        dp_abs = dp[ANGLE_BITS-1] ? (~dp + 1'b1) : dp;
    end

    // Split key and best-so-far decision.
    always_comb begin
        cur_split    = pair_idx_reg[PAIR_BITS-1:1];
        key          = (d1_reg < dist_reg) ? d1_reg : dist_reg;
        take_split   = (cur_split == '0) || (key < best_key_reg);
        chosen_split = take_split ? cur_split : best_split_reg;
    end

    // Sequencer and datapath next values.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        electron_next   = electron_reg;
        own_next        = own_reg;
        partner_next    = partner_reg;
        pair_idx_next   = pair_idx_reg;
        dphi_abs_next   = dphi_abs_reg;
        eta_sq_next     = eta_sq_reg;
        dist_next       = dist_reg;
        d1_next         = d1_reg;
        best_key_next   = best_key_reg;
        best_split_next = best_split_reg;
        res_data_next   = res_data_reg;
        res_user_next   = res_user_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        sq_op           = ETA_BITS'(dphi_abs_reg);

        // Output register drains on the downstream handshake.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (store_we) begin
                        own_next[count_reg[LEPTON_POS_BITS-1:0]] =
                            s_tdata[IN_OWN_LSB +: INDEX_BITS];
                        partner_next[count_reg[LEPTON_POS_BITS-1:0]] =
                            s_tdata[IN_PARTNER_LSB +: PARTNER_BITS];
                    end
                    if (count_reg < COUNT_SAT) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        electron_next = s_tuser;
                        state_next    = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                res_data_next = '0;
                res_user_next = '0;
                if (count_reg != COUNT_FULL) begin
                    state_next = ST_DONE;
                end else if (electron_reg && match.found) begin
                    res_data_next = OUT_DATA_BITS'({match.p2_second, match.p2_first,
                                                    match.p1_second, match.p1_first});
                    res_user_next[USER_VALID] = 1'b1;
                    res_user_next[USER_MATCH] = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    pair_idx_next = '0;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                sq_op         = de_abs[ETA_BITS-1:0];
                dphi_abs_next = dp_abs;
                state_next    = ST_SQ_PHI;
            end
            ST_SQ_PHI: begin
                sq_op       = ETA_BITS'(dphi_abs_reg);
                eta_sq_next = sq_out;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                dist_next  = {1'b0, eta_sq_reg} + {1'b0, sq_out};
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (!pair_idx_reg[0]) begin
                    // First pair of a split: hold its distance.
                    d1_next       = dist_reg;
                    pair_idx_next = pair_idx_reg + 1'b1;
                    state_next    = ST_READ;
                end else begin
                    if (take_split) begin
                        best_key_next   = key;
                        best_split_next = cur_split;
                    end
                    if (pair_idx_reg == PAIR_BITS'(NUM_PAIRS - 1)) begin
                        res_data_next = OUT_DATA_BITS'({
                            pair_pos(PAIR_BITS'(chosen_split), 2'd3),
                            pair_pos(PAIR_BITS'(chosen_split), 2'd2),
                            pair_pos(PAIR_BITS'(chosen_split), 2'd1),
                            pair_pos(PAIR_BITS'(chosen_split), 2'd0)});
                        res_user_next = '0;
                        res_user_next[USER_VALID] = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        pair_idx_next = pair_idx_reg + 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_data_next = res_data_reg;
                    out_user_next = res_user_reg;
                    count_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        electron_reg   <= electron_next;
        own_reg        <= own_next;
        partner_reg    <= partner_next;
        pair_idx_reg   <= pair_idx_next;
        dphi_abs_reg   <= dphi_abs_next;
        eta_sq_reg     <= eta_sq_next;
        dist_reg       <= dist_next;
        d1_reg         <= d1_next;
        best_key_reg   <= best_key_next;
        best_split_reg <= best_split_next;
        res_data_reg   <= res_data_next;
        res_user_reg   <= res_user_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flp_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module flp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flp_sq_unit.sv -----
// Shared squaring unit with a registered product, used for both angle differences.
// Depends on flp_pkg.
`default_nettype none

module flp_sq_unit
    import flp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [ETA_BITS-1:0] op,
    output logic      [SQ_BITS-1:0]  sq_reg
);

    // One unsigned square per cycle, computed at the full product width.
    always_ff @(posedge aclk) begin
        sq_reg <= SQ_BITS'(op) * SQ_BITS'(op);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flp_match.sv -----
// Reciprocal partner search over the four stored leptons.
// Depends on flp_pkg.
`default_nettype none

module flp_match
    import flp_pkg::*;
(
    input  wire logic [MAX_LEPTONS-1:0][INDEX_BITS-1:0]   own_idx,
    input  wire logic [MAX_LEPTONS-1:0][PARTNER_BITS-1:0] partner_idx,
    output pairing_t                                      match
);

    // Scan the pairs from last to first so that the earliest match wins.
    always_comb begin
        logic [LEPTON_POS_BITS-1:0] lo;
        logic [LEPTON_POS_BITS-1:0] hi;
        match = '0;
        for (int k = NUM_PAIRS - 1; k >= 0; k--) begin
            lo = pair_pos(PAIR_BITS'(k), 2'd0);
            hi = pair_pos(PAIR_BITS'(k), 2'd1);
            if (!partner_idx[lo][PARTNER_BITS-1] && !partner_idx[hi][PARTNER_BITS-1] &&
                partner_idx[lo][INDEX_BITS-1:0] == own_idx[hi] &&
                partner_idx[hi][INDEX_BITS-1:0] == own_idx[lo]) begin
                match.found     = 1'b1;
                match.p1_first  = lo;
                match.p1_second = hi;
                match.p2_first  = pair_pos(PAIR_BITS'(k), 2'd2);
                match.p2_second = pair_pos(PAIR_BITS'(k), 2'd3);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flp_checker.sv -----
// Port-level checks of the four-lepton pairing results, bound to the top level.
// Depends on flp_pkg and four_lepton_pairing.
`default_nettype none

module flp_checker
    import flp_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_tdata,
    input wire logic [OUT_USER_BITS-1:0] m_tuser
);

    // A stalled result holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An invalid event carries all-zero pair fields and no match flag.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_VALID] |-> m_tdata == '0 && !m_tuser[USER_MATCH])
        else $error("invalid result with nonzero fields");

    // A valid result is a true split: lower position first, four distinct positions.
    a_partition: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_VALID] |->
            m_tdata[1:0] < m_tdata[3:2] && m_tdata[5:4] < m_tdata[7:6] &&
            m_tdata[1:0] != m_tdata[5:4] && m_tdata[1:0] != m_tdata[7:6] &&
            m_tdata[3:2] != m_tdata[5:4] && m_tdata[3:2] != m_tdata[7:6])
        else $error("result is not a split of four positions");

    // A distance-based split always puts position 0 in the first pair.
    a_split_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_VALID] && !m_tuser[USER_MATCH] |-> m_tdata[1:0] == 2'd0)
        else $error("distance split without position 0 first");

endmodule

bind four_lepton_pairing flp_checker u_flp_checker (.*);

`default_nettype wire

// ----- test/flp_pairing_check.sv -----
// Scoreboard for the four-lepton pairing block: watches both stream channels,
// predicts each pairing result and compares it field by field.
// Depends on flp_pkg for the field widths and the tdata/tuser layout.
`timescale 1ns / 1ps

module flp_pairing_check
    import flp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    // tdata from bit 0: lepton_eta, lepton_phi, own_index, partner_index, zero fill
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // tuser: is_electron
    input  wire logic                     s_tuser,
    input  wire logic                     s_tlast,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    // tdata from bit 0: pair1_first, pair1_second, pair2_first, pair2_second
    input  wire logic [OUT_DATA_BITS-1:0] m_tdata,
    // tuser from bit 0: valid_res, used_partner_match
    input  wire logic [OUT_USER_BITS-1:0] m_tuser,
    output int                            outstanding,
    output int                            mismatches
);

    typedef struct packed {
        logic                       valid_res;
        logic [LEPTON_POS_BITS-1:0] p1_first;
        logic [LEPTON_POS_BITS-1:0] p1_second;
        logic [LEPTON_POS_BITS-1:0] p2_first;
        logic [LEPTON_POS_BITS-1:0] p2_second;
        logic                       partner_match;
    } pairing_result_t;

    // Leptons of the event being collected, in arrival order.
    logic signed [ETA_BITS-1:0]     eta_mem     [MAX_LEPTONS];
    logic signed [ANGLE_BITS-1:0]   phi_mem     [MAX_LEPTONS];
    logic        [INDEX_BITS-1:0]   own_mem     [MAX_LEPTONS];
    logic signed [PARTNER_BITS-1:0] partner_mem [MAX_LEPTONS];
    int unsigned                    leptons_seen;

    pairing_result_t expected_pairings [$];
    pairing_result_t want;
    int              fail_count = 0;

    // Squared separation of two stored leptons; phi difference wraps around 2pi.
    function automatic longint pair_sep2(input int a, input int b);
        logic signed [ETA_BITS:0]     deta;
        logic signed [ANGLE_BITS-1:0] dphi;
        longint                       e;
        longint                       p;
        deta = eta_mem[a] - eta_mem[b];
        dphi = phi_mem[a] - phi_mem[b];
        e = deta;
        p = dphi;
        return e * e + p * p;
    endfunction

    // A split is rated by the closer of its two pairs.
    function automatic longint split_cost(input int a, input int b, input int c, input int d);
        longint d1;
        longint d2;
        d1 = pair_sep2(a, b);
        d2 = pair_sep2(c, d);
        return (d1 < d2) ? d1 : d2;
    endfunction

    // Store one accepted lepton and, when it closes the event, queue the pairing.
    task automatic absorb_lepton(
        input logic [IN_DATA_BITS-1:0] word,
        input logic                    electron,
        input logic                    closes
    );
        pairing_result_t res;
        logic            found;
        longint          best_cost;
        longint          cost;
        int              i;
        int              j;
        int              k;
        int              slot;
        if (leptons_seen < MAX_LEPTONS) begin
            eta_mem[leptons_seen]     = word[IN_ETA_LSB +: ETA_BITS];
            phi_mem[leptons_seen]     = word[IN_PHI_LSB +: ANGLE_BITS];
            own_mem[leptons_seen]     = word[IN_OWN_LSB +: INDEX_BITS];
            partner_mem[leptons_seen] = word[IN_PARTNER_LSB +: PARTNER_BITS];
        end
        if (leptons_seen < COUNT_SAT) begin
            leptons_seen++;
        end
        if (closes) begin
            res   = '0;
            found = 1'b0;
            if (leptons_seen == MAX_LEPTONS) begin
                res.valid_res = 1'b1;
                // Electron events: the first pair, in scan order, pointing at each other.
                if (electron) begin
                    for (i = 0; i < MAX_LEPTONS - 1; i++) begin
                        for (j = i + 1; j < MAX_LEPTONS; j++) begin
                            if (!found && partner_mem[i] >= 0 && partner_mem[j] >= 0 &&
                                partner_mem[i][INDEX_BITS-1:0] == own_mem[j] &&
                                partner_mem[j][INDEX_BITS-1:0] == own_mem[i]) begin
                                found             = 1'b1;
                                res.partner_match = 1'b1;
                                res.p1_first      = LEPTON_POS_BITS'(i);
                                res.p1_second     = LEPTON_POS_BITS'(j);
                                slot = 0;
                                for (k = 0; k < MAX_LEPTONS; k++) begin
                                    if (k != i && k != j) begin
                                        if (slot == 0) begin
                                            res.p2_first = LEPTON_POS_BITS'(k);
                                        end else begin
                                            res.p2_second = LEPTON_POS_BITS'(k);
                                        end
                                        slot++;
                                    end
                                end
                            end
                        end
                    end
                end
                // Otherwise the split whose closer pair is closest; ties keep the earlier one.
                if (!found) begin
                    {res.p1_first, res.p1_second, res.p2_first, res.p2_second} =
                        {2'd0, 2'd1, 2'd2, 2'd3};
                    best_cost = split_cost(0, 1, 2, 3);
                    cost = split_cost(0, 2, 1, 3);
                    if (cost < best_cost) begin
                        best_cost = cost;
                        {res.p1_first, res.p1_second, res.p2_first, res.p2_second} =
                            {2'd0, 2'd2, 2'd1, 2'd3};
                    end
                    cost = split_cost(0, 3, 1, 2);
                    if (cost < best_cost) begin
                        {res.p1_first, res.p1_second, res.p2_first, res.p2_second} =
                            {2'd0, 2'd3, 2'd1, 2'd2};
                    end
                end
            end
            expected_pairings.push_back(res);
            leptons_seen = 0;
        end
    endtask

    task automatic compare_field(input string field, input int expected_val, input int actual);
        if (expected_val != actual) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, expected_val, actual);
        end
    endtask

    // Requests are taken into the prediction and results checked at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            leptons_seen = 0;
            expected_pairings.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_lepton(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_pairings.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected, tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_pairings.pop_front();
                    compare_field("valid_res", int'(want.valid_res),
                                  int'(m_tuser[USER_VALID]));
                    compare_field("pair1_first", int'(want.p1_first),
                                  int'(m_tdata[0*LEPTON_POS_BITS +: LEPTON_POS_BITS]));
                    compare_field("pair1_second", int'(want.p1_second),
                                  int'(m_tdata[1*LEPTON_POS_BITS +: LEPTON_POS_BITS]));
                    compare_field("pair2_first", int'(want.p2_first),
                                  int'(m_tdata[2*LEPTON_POS_BITS +: LEPTON_POS_BITS]));
                    compare_field("pair2_second", int'(want.p2_second),
                                  int'(m_tdata[3*LEPTON_POS_BITS +: LEPTON_POS_BITS]));
                    compare_field("used_partner_match", int'(want.partner_match),
                                  int'(m_tuser[USER_MATCH]));
                end
            end
        end
        outstanding <= expected_pairings.size();
        mismatches  <= fail_count;
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the four-lepton pairing testbench: clock, reset, lepton stimulus,
// result-side flow control, watchdog and verdict.
// Depends on flp_pkg, four_lepton_pairing and flp_pairing_check.
`timescale 1ns / 1ps

module tb_top;
    import flp_pkg::*;

    localparam int LEPTON_TARGET = 1800;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;

    int pairings_pending;
    int pairing_errors;
    int leptons_offered = 0;
    bit send_steady     = 1'b0;

    // Result side flow control state.
    int results_taken  = 0;
    int stall_left     = 0;
    int mode_left      = 0;
    bit sink_steady    = 1'b0;
    bit long_hold_done = 1'b0;

    int quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    four_lepton_pairing DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    flp_pairing_check u_pairing_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (pairings_pending),
        .mismatches  (pairing_errors)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Offer one lepton request and hold it until taken, then maybe idle a while.
    task automatic offer_lepton(
        input logic                     electron,
        input logic signed [ETA_BITS-1:0]     eta,
        input logic signed [ANGLE_BITS-1:0]   phi,
        input logic        [INDEX_BITS-1:0]   own,
        input logic signed [PARTNER_BITS-1:0] partner,
        input logic                     closes
    );
        logic [IN_DATA_BITS-1:0] word;
        int                      gap;
        word = '0;
        word[IN_ETA_LSB +: ETA_BITS]         = eta;
        word[IN_PHI_LSB +: ANGLE_BITS]       = phi;
        word[IN_OWN_LSB +: INDEX_BITS]       = own;
        word[IN_PARTNER_LSB +: PARTNER_BITS] = partner;
        s_tdata  <= word;
        s_tuser  <= electron;
        s_tlast  <= closes;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        leptons_offered++;
        gap = (send_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pairings_pending != 0) begin
            @(posedge aclk);
        end
    endtask

    // Result side: random stalls with calm stretches, and one long hold-off
    // while the sender keeps going so that the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_taken++;
            end
            if (mode_left == 0) begin
                sink_steady = ($urandom_range(0, 3) == 0);
                mode_left   = $urandom_range(40, 160);
            end else begin
                mode_left--;
            end
            if (!long_hold_done && results_taken >= 12) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end else if (stall_left == 0 && !sink_steady && $urandom_range(0, 2) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus: directed events first, then random events.
    initial begin
        int                       n;
        int                       m;
        int                       k;
        int                       i;
        int                       j;
        int                       style;
        int                       event_no;
        logic                     elec;
        logic signed [ETA_BITS-1:0]     eta_base;
        logic signed [ANGLE_BITS-1:0]   phi_base;
        logic signed [ETA_BITS-1:0]     eta_v;
        logic signed [ANGLE_BITS-1:0]   phi_v;
        logic        [INDEX_BITS-1:0]   owns     [8];
        logic signed [PARTNER_BITS-1:0] partners [8];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Muon event at the extremes of every field.
        offer_lepton(0, -4096, -2048,    0, -1024, 0);
        offer_lepton(1,  4095,  2047, 1023,  1023, 0);
        offer_lepton(0, -4096,  2047, 1023,    -1, 0);
        offer_lepton(0,  4095, -2048,    0,     0, 1);
        // Electron event with a reciprocal pair at positions 1 and 3.
        offer_lepton(0,  10,  20,  5,  -1, 0);
        offer_lepton(0, -30,  40,  7,  11, 0);
        offer_lepton(1,  50, -60,  9,   9, 0);
        offer_lepton(1,  70,  80, 11,   7, 1);
        // Electron event where partners point around but never back; phi wraps.
        offer_lepton(1,  0,  2040, 100,  200, 0);
        offer_lepton(0,  0, -2040, 200,  300, 0);
        offer_lepton(1, 50,     0, 300,  100, 0);
        offer_lepton(1, 60,  1000, 400,   -1, 1);
        // All four leptons on one spot: every split ties, the first one wins.
        offer_lepton(0, 123, -77, 1, 2, 0);
        offer_lepton(0, 123, -77, 2, 1, 0);
        offer_lepton(0, 123, -77, 3, 4, 0);
        offer_lepton(0, 123, -77, 4, 3, 1);
        // Single lepton event.
        offer_lepton(1, -5, 5, 12, 13, 1);
        // Six leptons: too many, the count saturates.
        for (k = 0; k < 6; k++) begin
            offer_lepton(0, ETA_BITS'(k * 100), ANGLE_BITS'(-k * 200), INDEX_BITS'(k),
                         PARTNER_BITS'(k + 1), k == 5);
        end
        // Two leptons only.
        offer_lepton(1, 300, 300, 20, 21, 0);
        offer_lepton(1, 301, 299, 21, 20, 1);
        drain_results();

        // Random events, mostly four leptons with shaped content.
        event_no = 0;
        while (leptons_offered < LEPTON_TARGET) begin
            if ($urandom_range(0, 7) < 6) begin
                n = 4;
            end else begin
                n = $urandom_range(1, 6);
                if (n >= 4) begin
                    n++;
                end
            end
            m           = (n < MAX_LEPTONS) ? n : MAX_LEPTONS;
            elec        = 1'($urandom_range(0, 1));
            style       = $urandom_range(0, 3);
            send_steady = ($urandom_range(0, 3) == 0);
            eta_base    = ETA_BITS'($urandom);
            phi_base    = ANGLE_BITS'($urandom);
            for (k = 0; k < n; k++) begin
                owns[k] = INDEX_BITS'($urandom);
            end
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 3))
                    0:       partners[k] = -11'sd1 - 11'($urandom_range(0, 1023));
                    1:       partners[k] = PARTNER_BITS'($urandom);
                    default: partners[k] = {1'b0, owns[$urandom_range(0, n - 1)]};
                endcase
            end
            // Plant a reciprocal pair in most electron events.
            if (elec && m >= 2 && $urandom_range(0, 2) != 0) begin
                i = $urandom_range(0, m - 2);
                j = $urandom_range(i + 1, m - 1);
                partners[i] = {1'b0, owns[j]};
                partners[j] = {1'b0, owns[i]};
            end
            for (k = 0; k < n; k++) begin
                case (style)
                    0: begin
                        eta_v = ETA_BITS'($urandom);
                        phi_v = ANGLE_BITS'($urandom);
                    end
                    1: begin
                        eta_v = eta_base + ETA_BITS'($urandom_range(0, 128)) - ETA_BITS'(64);
                        phi_v = phi_base + ANGLE_BITS'($urandom_range(0, 128)) - ANGLE_BITS'(64);
                    end
                    2: begin
                        eta_v = eta_base + ETA_BITS'($urandom_range(0, 64));
                        if ($urandom_range(0, 1) == 1) begin
                            phi_v = 12'h7ff - ANGLE_BITS'($urandom_range(0, 40));
                        end else begin
                            phi_v = 12'h800 + ANGLE_BITS'($urandom_range(0, 40));
                        end
                    end
                    default: begin
                        eta_v = eta_base;
                        phi_v = phi_base;
                    end
                endcase
                offer_lepton((k == n - 1) ? elec : 1'($urandom), eta_v, phi_v,
                             owns[k], partners[k], k == n - 1);
            end
            event_no++;
            if (event_no == 150) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pairing_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
